// ----- rtl/utf8d_pkg.sv -----
package utf8d_pkg;

  // Beat widths on the two stream ports.
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 40;

  // Field widths.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned AvailW = 3;
  localparam int unsigned CodeW  = 31;
  localparam int unsigned UsedW  = 3;

  // Largest count of bytes in one window.
  localparam logic [AvailW-1:0] MaxAvail = 3'd6;

  // Lead byte class boundaries.
  localparam logic [ByteW-1:0] Lead1Lim = 8'h80;
  localparam logic [ByteW-1:0] Lead2Lim = 8'he0;
  localparam logic [ByteW-1:0] Lead3Lim = 8'hf0;
  localparam logic [ByteW-1:0] Lead4Lim = 8'hf8;
  localparam logic [ByteW-1:0] Lead5Lim = 8'hfc;
  localparam logic [ByteW-1:0] Lead6Lim = 8'hfe;

  // Continuation byte form: 10xxxxxx.
  localparam logic [ByteW-1:0] ContMask = 8'hc0;
  localparam logic [ByteW-1:0] ContTag  = 8'h80;

  // One decode window as it sits in the input register.
  typedef struct packed {
    logic [AvailW-1:0] avail;
    logic [ByteW-1:0]  byte5;
    logic [ByteW-1:0]  byte4;
    logic [ByteW-1:0]  byte3;
    logic [ByteW-1:0]  byte2;
    logic [ByteW-1:0]  byte1;
    logic [ByteW-1:0]  byte0;
  } window_t;

  // One decoded result.
  typedef struct packed {
    logic             ok;
    logic [UsedW-1:0] consumed;
    logic [CodeW-1:0] code_point;
  } result_t;

endpackage

// ----- rtl/utf8_sequence_decoder_top.sv -----
// Channel  | Dir | tdata fields (low bit up)                           | Beat
// s_axis   | in  | byte0, byte1, byte2, byte3, byte4, byte5, avail, pad | one window
// m_axis   | out | code_point, consumed, ok, pad                        | one result
//
// One window is taken per cycle while m_axis is not stalled; each beat gives exactly one result.
// A window moves from s_axis into the input register, is decoded by a
// single level of compare and mask logic, and lands in the result register:
// the result register drives m_axis directly.
// Reset clears both stage valid flags. A stall on m_axis holds the result
// register, and s_axis keeps taking beats while the input register is free.
module utf8_sequence_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // byte0[7:0], byte1[15:8], byte2[23:16], byte3[31:24], byte4[39:32],
  // byte5[47:40], avail[50:48], zero pad[55:51]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // code_point[30:0], consumed[33:31], ok[34], zero pad[39:35]
  output logic [39:0] m_axis_tdata
);

  localparam int unsigned WinW = $bits(utf8d_pkg::window_t);
  localparam int unsigned ResW = $bits(utf8d_pkg::result_t);

  utf8d_pkg::window_t win;
  logic               win_valid;
  utf8d_pkg::result_t res;
  utf8d_pkg::result_t res_next;
  logic               res_valid;
  logic               res_free;
  logic               win_free;

  logic [utf8d_pkg::ByteW-1:0]  lead;
  logic [utf8d_pkg::AvailW-1:0] avail_c;
  logic [2:0]                   n_cont;
  logic [5:0]                   cont_ok;
  logic                         all_ok;
  logic [utf8d_pkg::CodeW-1:0]  acc;

  // Stage handshakes: each register is free when empty or draining.
  assign res_free      = !res_valid || m_axis_tready;
  assign win_free      = !win_valid || res_free;
  assign s_axis_tready = win_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (win_free) begin
      win_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (win_free && s_axis_tvalid) begin
      win <= utf8d_pkg::window_t'(s_axis_tdata[WinW-1:0]);
    end
  end

  // Continuation count from the lead byte class.
  always_comb begin
    lead = win.byte0;
    if (lead < utf8d_pkg::Lead1Lim) begin
      n_cont = 3'd0;
    end else if (lead < utf8d_pkg::Lead2Lim) begin
      n_cont = 3'd1;
    end else if (lead < utf8d_pkg::Lead3Lim) begin
      n_cont = 3'd2;
    end else if (lead < utf8d_pkg::Lead4Lim) begin
      n_cont = 3'd3;
    end else if (lead < utf8d_pkg::Lead5Lim) begin
      n_cont = 3'd4;
    end else if (lead < utf8d_pkg::Lead6Lim) begin
      n_cont = 3'd5;
    end else begin
      n_cont = 3'd0;
    end
  end

  // Out-of-range avail counts as a full window.
  assign avail_c = (win.avail > utf8d_pkg::MaxAvail) ? utf8d_pkg::MaxAvail : win.avail;

  // Form check on each following byte; bytes past the sequence always pass.
  always_comb begin
    cont_ok[0] = 1'b1;
    cont_ok[1] = (n_cont < 3'd1) ||
                 ((win.byte1 & utf8d_pkg::ContMask) == utf8d_pkg::ContTag);
    cont_ok[2] = (n_cont < 3'd2) ||
                 ((win.byte2 & utf8d_pkg::ContMask) == utf8d_pkg::ContTag);
    cont_ok[3] = (n_cont < 3'd3) ||
                 ((win.byte3 & utf8d_pkg::ContMask) == utf8d_pkg::ContTag);
    cont_ok[4] = (n_cont < 3'd4) ||
                 ((win.byte4 & utf8d_pkg::ContMask) == utf8d_pkg::ContTag);
    cont_ok[5] = (n_cont < 3'd5) ||
                 ((win.byte5 & utf8d_pkg::ContMask) == utf8d_pkg::ContTag);
    all_ok     = &cont_ok;
  end

  // Masked lead bits followed by the six-bit payloads; a lone lead byte passes as is.
  always_comb begin
    case (n_cont)
      3'd1: acc = {20'd0, lead[4:0], win.byte1[5:0]};
      3'd2: acc = {15'd0, lead[3:0], win.byte1[5:0], win.byte2[5:0]};
      3'd3: acc = {10'd0, lead[2:0], win.byte1[5:0], win.byte2[5:0],
                   win.byte3[5:0]};
      3'd4: acc = {5'd0, lead[1:0], win.byte1[5:0], win.byte2[5:0],
                   win.byte3[5:0], win.byte4[5:0]};
      3'd5: acc = {lead[0], win.byte1[5:0], win.byte2[5:0], win.byte3[5:0],
                   win.byte4[5:0], win.byte5[5:0]};
      default: acc = {23'd0, lead};
    endcase
  end

  // Pick the decoded value, the raw lead byte, or the end-of-buffer result.
  always_comb begin
    if (avail_c == '0) begin
      res_next.code_point = '0;
      res_next.consumed   = '0;
      res_next.ok         = 1'b0;
    end else if ((n_cont != 3'd0) && ({1'b0, n_cont} < {1'b0, avail_c}) && all_ok) begin
      res_next.code_point = acc;
      res_next.consumed   = n_cont + 3'd1;
      res_next.ok         = 1'b1;
    end else begin
      res_next.code_point = {23'd0, lead};
      res_next.consumed   = 3'd1;
      res_next.ok         = 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && win_valid) begin
      res <= res_next;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {{(utf8d_pkg::OutDataW - ResW){1'b0}}, res};

endmodule

// ----- rtl/utf8d_checker.sv -----
module utf8d_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // A stalled result beat holds.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  // End of buffer gives an all-zero result.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[34] |-> m_axis_tdata[33:0] == 34'd0)
    else $error("end-of-buffer result not zero");

  // A decode uses one to six bytes and never more than a window holds.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[34] |->
      m_axis_tdata[33:31] != 3'd0 && m_axis_tdata[33:31] != 3'd7)
    else $error("consumed count out of range");

  // A window taken while no result is shown brings a valid result through the input and result registers.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
    else $error("result missing after accepted window");

  // The pad bits of a result stay zero.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[39:35] == 5'd0)
    else $error("result pad bits set");

endmodule

bind utf8_sequence_decoder_top utf8d_checker u_utf8d_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- bench/utf8_sequence_decoder_top_test.sv -----
module utf8_sequence_decoder_top_test;

  // Long receiver hold-off and the quiet-cycle limit of the watchdog.
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned QuietLimit = 1000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  utf8d_pkg::window_t pending_windows[$];
  utf8d_pkg::result_t expected_results[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned windows_taken = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count = 0;

  utf8_sequence_decoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Expected decode of one window: the lead byte class sets how many
  // continuation bytes follow; any shortfall or bad tag falls back to the raw lead; no bytes give all zero.
  function automatic utf8d_pkg::result_t decode_window(utf8d_pkg::window_t w);
    utf8d_pkg::result_t           r;
    logic [utf8d_pkg::AvailW-1:0] have;
    logic [utf8d_pkg::ByteW-1:0]  lead;
    logic [utf8d_pkg::ByteW-1:0]  nxt;
    logic [utf8d_pkg::ByteW-1:0]  keep;
    int unsigned                  follow;
    logic [31:0]                  acc;
    logic                         good;
    r = '0;
    have = (w.avail > utf8d_pkg::MaxAvail) ? utf8d_pkg::MaxAvail : w.avail;
    if (have == 0) return r;
    lead = w.byte0;
    if (lead < utf8d_pkg::Lead1Lim) follow = 0;
    else if (lead < utf8d_pkg::Lead2Lim) follow = 1;
    else if (lead < utf8d_pkg::Lead3Lim) follow = 2;
    else if (lead < utf8d_pkg::Lead4Lim) follow = 3;
    else if (lead < utf8d_pkg::Lead5Lim) follow = 4;
    else if (lead < utf8d_pkg::Lead6Lim) follow = 5;
    else follow = 0;
    r.ok = 1'b1;
    r.consumed = utf8d_pkg::UsedW'(1);
    r.code_point = utf8d_pkg::CodeW'(lead);
    if (follow > 0 && follow + 1 <= have) begin
      keep = 8'hff >> (follow + 2);
      acc = 32'(lead & keep);
      good = 1'b1;
      for (int i = 1; i <= follow; i++) begin
        nxt = w[utf8d_pkg::ByteW*i +: utf8d_pkg::ByteW];
        if ((nxt & utf8d_pkg::ContMask) != utf8d_pkg::ContTag) good = 1'b0;
        acc = (acc << 6) | 32'(nxt & 8'h3f);
      end
      if (good) begin
        r.code_point = acc[utf8d_pkg::CodeW-1:0];
        r.consumed = utf8d_pkg::UsedW'(follow + 1);
      end
    end
    return r;
  endfunction

  function automatic utf8d_pkg::window_t mk(logic [7:0] b0, logic [7:0] b1,
                                            logic [7:0] b2, logic [7:0] b3,
                                            logic [7:0] b4, logic [7:0] b5,
                                            logic [2:0] av);
    return {av, b5, b4, b3, b2, b1, b0};
  endfunction

  // Mostly well-formed sequences with random payload, then truncations,
  // broken continuation bytes, invalid leads, end of buffer and pure noise.
  function automatic utf8d_pkg::window_t random_window();
    utf8d_pkg::window_t          w;
    int unsigned                 pick;
    int unsigned                 len;
    int unsigned                 bad_at;
    logic [1:0]                  tag;
    logic [utf8d_pkg::ByteW-1:0] lead;
    w = '0;
    w[31:0] = $urandom();
    w[47:32] = 16'($urandom());
    w.avail = utf8d_pkg::AvailW'($urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 84) begin
      len = (pick < 60) ? $urandom_range(1, 6) : $urandom_range(2, 6);
      case (len)
        1: lead = 8'($urandom_range(0, utf8d_pkg::Lead1Lim - 1));
        2: lead = 8'($urandom_range(utf8d_pkg::Lead1Lim, utf8d_pkg::Lead2Lim - 1));
        3: lead = 8'($urandom_range(utf8d_pkg::Lead2Lim, utf8d_pkg::Lead3Lim - 1));
        4: lead = 8'($urandom_range(utf8d_pkg::Lead3Lim, utf8d_pkg::Lead4Lim - 1));
        5: lead = 8'($urandom_range(utf8d_pkg::Lead4Lim, utf8d_pkg::Lead5Lim - 1));
        default: lead = 8'($urandom_range(utf8d_pkg::Lead5Lim, utf8d_pkg::Lead6Lim - 1));
      endcase
      w.byte0 = lead;
      for (int i = 1; i < len; i++)
        w[utf8d_pkg::ByteW*i +: utf8d_pkg::ByteW] =
          utf8d_pkg::ContTag | 8'($urandom_range(63));
      if (pick < 60) begin
        w.avail = utf8d_pkg::AvailW'($urandom_range(len, 7));
      end else if (pick < 72) begin
        w.avail = utf8d_pkg::AvailW'($urandom_range(1, len - 1));
      end else begin
        w.avail = utf8d_pkg::AvailW'($urandom_range(len, 7));
        bad_at = $urandom_range(1, len - 1);
        tag = 2'($urandom_range(2));
        if (tag == 2'b10) tag = 2'b11;
        w[utf8d_pkg::ByteW*bad_at +: utf8d_pkg::ByteW] = {tag, 6'($urandom_range(63))};
      end
    end else if (pick < 88) begin
      w.byte0 = utf8d_pkg::Lead6Lim | 8'($urandom_range(1));
      w.avail = utf8d_pkg::AvailW'($urandom_range(1, 7));
    end else if (pick < 92) begin
      w.avail = '0;
    end
    return w;
  endfunction

  // Sender: offers the next pending window, with random idle gaps, whenever the current beat has gone.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_windows.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, pending_windows.pop_front()};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done < holds_asked) begin
      m_axis_tready <= 1'b0;
      hold_left <= HoldCycles;
      holds_done <= holds_done + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Scoreboard: check the result beat first, then record the window beat.
  always @(posedge clk) begin : scoreboard
    utf8d_pkg::result_t got;
    utf8d_pkg::result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(utf8d_pkg::result_t)-1:0];
        results_checked++;
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result beat: code_point=%h consumed=%0d ok=%0d",
                     got.code_point, got.consumed, got.ok);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.code_point != want.code_point || got.consumed != want.consumed ||
              got.ok != want.ok) begin
            if (mismatch_count < 10)
              $display("result mismatch: expected code_point=%h consumed=%0d ok=%0d, %s",
                       want.code_point, want.consumed, want.ok,
                       $sformatf("got code_point=%h consumed=%0d ok=%0d",
                                 got.code_point, got.consumed, got.ok));
            mismatch_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(
          decode_window(s_axis_tdata[$bits(utf8d_pkg::window_t)-1:0]));
        windows_taken++;
      end
    end
  end

  // Watchdog on cycles with no beat on either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("timeout: no beat for %0d cycles", QuietLimit);
      $display("utf8_sequence_decoder_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Wait until every window has been taken and every result has come back.
  task automatic settle();
    while (pending_windows.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(int unsigned send_pct, int unsigned recv_pct, int unsigned count);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) pending_windows.push_back(random_window());
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed windows: ASCII extremes, every sequence length at both ends,
    // end of buffer, out-of-range avail, truncation, bad tags, invalid leads.
    pending_windows.push_back(mk(8'h41, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd0));
    pending_windows.push_back(mk(8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 3'd1));
    pending_windows.push_back(mk(8'h7f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd7));
    pending_windows.push_back(mk(8'hc2, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2));
    pending_windows.push_back(mk(8'hdf, 8'hbf, 8'hff, 8'hff, 8'hff, 8'hff, 3'd6));
    pending_windows.push_back(mk(8'h80, 8'hbf, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2));
    pending_windows.push_back(mk(8'hbf, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 3'd3));
    pending_windows.push_back(mk(8'he0, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 3'd3));
    pending_windows.push_back(mk(8'hef, 8'hbf, 8'hbf, 8'h00, 8'h00, 8'h00, 3'd4));
    pending_windows.push_back(mk(8'hf0, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00, 3'd4));
    pending_windows.push_back(mk(8'hf7, 8'hbf, 8'hbf, 8'hbf, 8'h00, 8'h00, 3'd5));
    pending_windows.push_back(mk(8'hf8, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00, 3'd5));
    pending_windows.push_back(mk(8'hfb, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hff, 3'd6));
    pending_windows.push_back(mk(8'hfc, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6));
    pending_windows.push_back(mk(8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 3'd6));
    pending_windows.push_back(mk(8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 3'd7));
    pending_windows.push_back(mk(8'he2, 8'h82, 8'hac, 8'h00, 8'h00, 8'h00, 3'd2));
    pending_windows.push_back(mk(8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 3'd5));
    pending_windows.push_back(mk(8'hc3, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2));
    pending_windows.push_back(mk(8'he2, 8'hc2, 8'hac, 8'h00, 8'h00, 8'h00, 3'd3));
    pending_windows.push_back(mk(8'hfc, 8'h80, 8'h80, 8'h80, 8'h80, 8'hc0, 3'd6));
    pending_windows.push_back(mk(8'hfe, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6));
    pending_windows.push_back(mk(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 3'd7));
    pending_windows.push_back(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd6));
    settle();

    // Random traffic under each flow-control mix.
    random_phase(0, 0, 320);
    random_phase(73, 0, 320);
    random_phase(0, 73, 320);
    random_phase(18, 18, 320);

    // Back-pressure: the receiver holds off while the sender keeps offering.
    @(negedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    holds_asked = holds_asked + 1;
    repeat (60) pending_windows.push_back(random_window());
    settle();
    repeat (10) @(posedge clk);

    $display("Decoded %0d windows: every lead class, truncation, bad continuation, end of buffer,",
             windows_taken);
    $display("over five flow-control mixes; %0d results checked, %0d mismatches.",
             results_checked, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("utf8_sequence_decoder_top test passed");
    end else begin
      $display("utf8_sequence_decoder_top test failed");
    end
    $finish;
  end

endmodule
